// ----- hw/rtl/tcsm_pkg.sv -----
// ----------------------------------------------------------------------------
// tcsm_pkg
// Types, codes and constants shared by the TCP connection state machine.
// ----------------------------------------------------------------------------
package tcsm_pkg;

  typedef enum logic [3:0] {
    ST_CLOSED      = 4'd0,
    ST_LISTEN      = 4'd1,
    ST_SYN_SENT    = 4'd2,
    ST_SYN_RECV    = 4'd3,
    ST_ESTABLISHED = 4'd4,
    ST_FIN_WAIT1   = 4'd5,
    ST_FIN_WAIT2   = 4'd6,
    ST_CLOSING     = 4'd7,
    ST_TIME_WAIT   = 4'd8,
    ST_CLOSE_WAIT  = 4'd9,
    ST_LAST_ACK    = 4'd10
  } conn_state_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SYN  = 2'd1,
    ACT_ACK  = 2'd2,
    ACT_DROP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_START_STATE = 2'd0,
    CFG_INITIAL_SEQ = 2'd1,
    CFG_ADV_WINDOW  = 2'd2
  } cfg_index_t;

  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned CfgIndexW   = 2;
  localparam logic [10:0] MinSegLen   = 11'd40;
  localparam logic [31:0] SynBytes    = 32'd24;
  localparam logic [31:0] AckBytes    = 32'd20;
  localparam logic [15:0] WindowReset = 16'hFFFF;

  typedef struct packed {
    logic        seg_syn;
    logic        seg_ack;
    logic        seg_fin;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack_num;
    logic [10:0] seg_len;
    logic        checksum_ok;
  } seg_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] out_seq;
    logic [31:0] out_ack_num;
    logic [15:0] out_window;
    logic [3:0]  conn_now;
    logic [31:0] pkts_in;
    logic [31:0] octets_in;
    logic [31:0] pkts_out;
    logic [31:0] octets_out;
  } res_t;

  typedef struct packed {
    conn_state_t conn;
    logic [31:0] send_seq;
    logic [31:0] expect_seq;
    logic [31:0] in_pkts;
    logic [31:0] in_bytes;
    logic [31:0] out_pkts;
    logic [31:0] out_bytes;
  } conn_ctx_t;

endpackage

// ----- hw/rtl/tcsm_ifs.sv -----
// ----------------------------------------------------------------------------
// tcsm channel interfaces
// Valid/ready channels for received segments and for result beats.
// ----------------------------------------------------------------------------
interface tcsm_seg_if;
  logic        valid;
  logic        ready;
  logic        seg_syn;
  logic        seg_ack;
  logic        seg_fin;
  logic [31:0] seg_seq;
  logic [31:0] seg_ack_num;
  logic [10:0] seg_len;
  logic        checksum_ok;

  modport source (
    output valid, seg_syn, seg_ack, seg_fin, seg_seq, seg_ack_num, seg_len, checksum_ok,
    input  ready
  );
  modport sink (
    input  valid, seg_syn, seg_ack, seg_fin, seg_seq, seg_ack_num, seg_len, checksum_ok,
    output ready
  );
endinterface

interface tcsm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] out_seq;
  logic [31:0] out_ack_num;
  logic [15:0] out_window;
  logic [3:0]  conn_now;
  logic [31:0] pkts_in;
  logic [31:0] octets_in;
  logic [31:0] pkts_out;
  logic [31:0] octets_out;

  modport source (
    output valid, action, out_seq, out_ack_num, out_window, conn_now,
           pkts_in, octets_in, pkts_out, octets_out,
    input  ready
  );
  modport sink (
    input  valid, action, out_seq, out_ack_num, out_window, conn_now,
           pkts_in, octets_in, pkts_out, octets_out,
    output ready
  );
endinterface

// ----- hw/rtl/tcsm_step.sv -----
// ----------------------------------------------------------------------------
// tcsm_step
// Per-segment update: next connection context and the result beat.
// ----------------------------------------------------------------------------
module tcsm_step import tcsm_pkg::*; (
  input  conn_ctx_t   ctx,
  input  seg_t        seg,
  input  logic [15:0] adv_window,
  output conn_ctx_t   ctx_next,
  output res_t        res
);

  logic drop;
  logic ack_gt;
  logic send_syn;
  logic send_ack;

  assign drop   = (seg.seg_len < MinSegLen) || !seg.checksum_ok;
  assign ack_gt = seg.seg_ack_num > ctx.send_seq;

  always_comb begin
    ctx_next = ctx;
    send_syn = 1'b0;
    send_ack = 1'b0;
    if (!drop) begin
      case (ctx.conn)
        ST_LISTEN: begin
          if (seg.seg_syn) begin
            ctx_next.expect_seq = seg.seg_seq + 32'd1;
            ctx_next.conn       = ST_SYN_RECV;
            send_syn            = 1'b1;
          end
        end
        ST_SYN_SENT: begin
          if (seg.seg_syn && seg.seg_ack && ack_gt) begin
            ctx_next.send_seq   = seg.seg_ack_num;
            ctx_next.expect_seq = seg.seg_seq + 32'd1;
            ctx_next.conn       = ST_ESTABLISHED;
            send_ack            = 1'b1;
          end
        end
        ST_SYN_RECV, ST_CLOSING, ST_LAST_ACK: begin
          if (seg.seg_ack && ack_gt) begin
            ctx_next.send_seq = seg.seg_ack_num;
            case (ctx.conn)
              ST_SYN_RECV: ctx_next.conn = ST_ESTABLISHED;
              ST_CLOSING:  ctx_next.conn = ST_TIME_WAIT;
              default:     ctx_next.conn = ST_CLOSED;
            endcase
          end
        end
        ST_ESTABLISHED, ST_FIN_WAIT1, ST_FIN_WAIT2: begin
          if (seg.seg_fin) begin
            ctx_next.conn = (ctx.conn == ST_ESTABLISHED) ? ST_CLOSE_WAIT : ST_TIME_WAIT;
            ctx_next.expect_seq = ctx.expect_seq + 32'd1;
            send_ack = 1'b1;
          end else if (seg.seg_ack && ack_gt) begin
            ctx_next.send_seq = seg.seg_ack_num;
            if (ctx.conn == ST_FIN_WAIT1) begin
              ctx_next.conn = ST_FIN_WAIT2;
            end
          end
        end
        ST_TIME_WAIT: begin
          send_ack = seg.seg_fin;
        end
        default: begin
          ctx_next.conn = ctx.conn;
        end
      endcase
      if (send_syn) begin
        ctx_next.out_pkts  = ctx.out_pkts + 32'd1;
        ctx_next.out_bytes = ctx.out_bytes + SynBytes;
      end else if (send_ack) begin
        ctx_next.out_pkts  = ctx.out_pkts + 32'd1;
        ctx_next.out_bytes = ctx.out_bytes + AckBytes;
      end
      ctx_next.in_pkts  = ctx.in_pkts + 32'd1;
      ctx_next.in_bytes = ctx.in_bytes + {21'd0, seg.seg_len};
    end
  end

  always_comb begin
    res.action      = ACT_NONE;
    res.out_seq     = '0;
    res.out_ack_num = '0;
    res.out_window  = '0;
    if (drop) begin
      res.action = ACT_DROP;
    end else if (send_syn) begin
      res.action     = ACT_SYN;
      res.out_seq    = ctx_next.send_seq;
      res.out_window = adv_window;
    end else if (send_ack) begin
      res.action      = ACT_ACK;
      res.out_seq     = ctx_next.send_seq;
      res.out_ack_num = ctx_next.expect_seq;
      res.out_window  = adv_window;
    end
    res.conn_now   = ctx_next.conn;
    res.pkts_in    = ctx_next.in_pkts;
    res.octets_in  = ctx_next.in_bytes;
    res.pkts_out   = ctx_next.out_pkts;
    res.octets_out = ctx_next.out_bytes;
  end

endmodule

// ----- hw/rtl/tcsm_ctx.sv -----
// ----------------------------------------------------------------------------
// tcsm_ctx
// Connection context and window registers, set by config writes and updates.
// ----------------------------------------------------------------------------
module tcsm_ctx import tcsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 update,
  input  conn_ctx_t            ctx_next,
  output conn_ctx_t            ctx,
  output logic [15:0]          adv_window
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.conn       <= ST_LISTEN;
      ctx.send_seq   <= '0;
      ctx.expect_seq <= '0;
      ctx.in_pkts    <= '0;
      ctx.in_bytes   <= '0;
      ctx.out_pkts   <= '0;
      ctx.out_bytes  <= '0;
      adv_window     <= WindowReset;
    end else if (cfg_wen) begin
      case (cfg_index_t'(cfg_index))
        CFG_START_STATE: ctx.conn <= conn_state_t'(cfg_data[3:0]);
        CFG_INITIAL_SEQ: ctx.send_seq <= cfg_data;
        CFG_ADV_WINDOW:  adv_window <= cfg_data[15:0];
        default:         adv_window <= adv_window;
      endcase
    end else if (update) begin
      ctx <= ctx_next;
    end
  end

endmodule

// ----- hw/rtl/tcp_connection_state_machine.sv -----
// ----------------------------------------------------------------------------
// tcp_connection_state_machine
// Receive-side TCP connection tracker with reply and traffic counters.
// ----------------------------------------------------------------------------
// Usage:
//   seg   : one received segment header per beat (flags, numbers, length,
//           checksum verdict).
//   res   : one result beat per segment: reply action and fields, the
//           connection state after the segment and four wrapping counters.
//   cfg_* : write port; index 0 start state, 1 initial send sequence,
//           2 advertised window. Write only while no segment is in flight.
// The segment is registered in the input stage at its accepting edge; the
// state update and result are computed from it and captured in the context
// and result registers together when the result register can advance, which
// raises res.valid; the result beat completes when res.ready is high.
// Throughput is one segment per cycle unless the result is stalled; the
// combinational update (one 32-bit compare and adders) sets that figure.
// Reset clears both stages, loads the listen state, send sequence 0,
// window 65535 and zero counters.
// A stalled result holds both stages; seg.ready drops once the input
// register is full behind it.
// ----------------------------------------------------------------------------
module tcp_connection_state_machine import tcsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  tcsm_seg_if.sink             seg,
  tcsm_res_if.source           res
);

  logic        s1_valid;
  seg_t        s1_seg;
  logic        res_valid;
  res_t        res_q;
  logic        advance;
  logic        update;
  conn_ctx_t   ctx;
  conn_ctx_t   ctx_next;
  res_t        res_d;
  logic [15:0] adv_window;

  assign advance   = !res_valid || res.ready;
  assign update    = s1_valid && advance;
  assign seg.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (seg.ready) begin
      s1_valid <= seg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seg.valid && seg.ready) begin
      s1_seg.seg_syn     <= seg.seg_syn;
      s1_seg.seg_ack     <= seg.seg_ack;
      s1_seg.seg_fin     <= seg.seg_fin;
      s1_seg.seg_seq     <= seg.seg_seq;
      s1_seg.seg_ack_num <= seg.seg_ack_num;
      s1_seg.seg_len     <= seg.seg_len;
      s1_seg.checksum_ok <= seg.checksum_ok;
    end
  end

  tcsm_ctx u_ctx (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .update     (update),
    .ctx_next   (ctx_next),
    .ctx        (ctx),
    .adv_window (adv_window)
  );

  tcsm_step u_step (
    .ctx        (ctx),
    .seg        (s1_seg),
    .adv_window (adv_window),
    .ctx_next   (ctx_next),
    .res        (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      res_q <= res_d;
    end
  end

  assign res.valid       = res_valid;
  assign res.action      = res_q.action;
  assign res.out_seq     = res_q.out_seq;
  assign res.out_ack_num = res_q.out_ack_num;
  assign res.out_window  = res_q.out_window;
  assign res.conn_now    = res_q.conn_now;
  assign res.pkts_in     = res_q.pkts_in;
  assign res.octets_in   = res_q.octets_in;
  assign res.pkts_out    = res_q.pkts_out;
  assign res.octets_out  = res_q.octets_out;

endmodule

// ----- hw/rtl/tcsm_checker.sv -----
// ----------------------------------------------------------------------------
// tcsm_checker
// Port-level checks on the result channel of the connection tracker.
// ----------------------------------------------------------------------------
module tcsm_checker import tcsm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  action,
  input logic [31:0] out_seq,
  input logic [31:0] out_ack_num,
  input logic [15:0] out_window,
  input logic [3:0]  conn_now,
  input logic [31:0] pkts_in
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(action) && $stable(out_seq)
      && $stable(pkts_in) && $stable(conn_now))
    else $error("stalled result beat changed");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && action == ACT_NONE |-> out_seq == '0 && out_ack_num == '0
      && out_window == '0)
    else $error("reply fields set with no reply");

  a_syn_reply: assert property (@(posedge clk) disable iff (rst)
    res_valid && action == ACT_SYN |-> conn_now == ST_SYN_RECV && out_ack_num == '0)
    else $error("SYN reply outside handshake");

endmodule

bind tcp_connection_state_machine tcsm_checker u_tcsm_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .action      (res.action),
  .out_seq     (res.out_seq),
  .out_ack_num (res.out_ack_num),
  .out_window  (res.out_window),
  .conn_now    (res.conn_now),
  .pkts_in     (res.pkts_in)
);

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the TCP connection state machine. A connection tracker
// inside the bench mirrors the connection state, the send and receive
// sequence numbers, the window and the four traffic counters. From each
// accepted segment beat it predicts the reply, the next state and the
// counters, and compares every result beat field by field in order.
// A short directed run walks the handshake, the close paths, ack
// comparisons at the wrap point, dropped segments and the register extremes.
// Random phases follow. Each phase reloads the registers while the block is
// idle and mostly sends segments that fit the current state. The sender and
// receiver idle patterns change from one phase to the next.
// ----------------------------------------------------------------------------
module tb_top;
  import tcsm_pkg::*;

  class conn_tracker;
    conn_ctx_t   ctx;
    logic [15:0] window;
    res_t        replies_due[$];
    int unsigned mismatches;

    function new();
      ctx.conn       = ST_LISTEN;
      ctx.send_seq   = '0;
      ctx.expect_seq = '0;
      ctx.in_pkts    = '0;
      ctx.in_bytes   = '0;
      ctx.out_pkts   = '0;
      ctx.out_bytes  = '0;
      window         = WindowReset;
      mismatches     = 0;
    endfunction

    function void load_register(cfg_index_t idx, logic [31:0] data);
      case (idx)
        CFG_START_STATE: ctx.conn = conn_state_t'(data[3:0]);
        CFG_INITIAL_SEQ: ctx.send_seq = data;
        CFG_ADV_WINDOW:  window = data[15:0];
        default: ;
      endcase
    endfunction

    // Take the ack only when it lies strictly above send_seq; returns 1 when
    // a completed active open needs an ACK reply.
    function bit accept_ack(logic [31:0] ackn, logic [31:0] seq, logic syn);
      if (ackn <= ctx.send_seq) return 1'b0;
      ctx.send_seq = ackn;
      case (ctx.conn)
        ST_SYN_SENT: begin
          if (syn) begin
            ctx.expect_seq = seq + 32'd1;
            ctx.conn = ST_ESTABLISHED;
            return 1'b1;
          end
        end
        ST_SYN_RECV:  ctx.conn = ST_ESTABLISHED;
        ST_FIN_WAIT1: ctx.conn = ST_FIN_WAIT2;
        ST_CLOSING:   ctx.conn = ST_TIME_WAIT;
        ST_LAST_ACK:  ctx.conn = ST_CLOSED;
        default: ;
      endcase
      return 1'b0;
    endfunction

    function void note_segment(seg_t s);
      res_t r;
      bit   reply_ack;
      r = '0;
      r.action = ACT_NONE;
      reply_ack = 1'b0;
      if (s.seg_len < MinSegLen || !s.checksum_ok) begin
        r.action = ACT_DROP;
      end else begin
        case (ctx.conn)
          ST_LISTEN: begin
            if (s.seg_syn) begin
              ctx.expect_seq = s.seg_seq + 32'd1;
              ctx.conn = ST_SYN_RECV;
              r.action = ACT_SYN;
              r.out_seq = ctx.send_seq;
              r.out_window = window;
              ctx.out_pkts += 32'd1;
              ctx.out_bytes += SynBytes;
            end
          end
          ST_SYN_SENT: begin
            if (s.seg_syn && s.seg_ack)
              reply_ack = accept_ack(s.seg_ack_num, s.seg_seq, s.seg_syn);
          end
          ST_SYN_RECV, ST_CLOSING, ST_LAST_ACK: begin
            if (s.seg_ack) void'(accept_ack(s.seg_ack_num, s.seg_seq, s.seg_syn));
          end
          ST_ESTABLISHED, ST_FIN_WAIT1, ST_FIN_WAIT2: begin
            if (s.seg_fin) begin
              ctx.conn = (ctx.conn == ST_ESTABLISHED) ? ST_CLOSE_WAIT : ST_TIME_WAIT;
              ctx.expect_seq += 32'd1;
              reply_ack = 1'b1;
            end else if (s.seg_ack) begin
              void'(accept_ack(s.seg_ack_num, s.seg_seq, s.seg_syn));
            end
          end
          ST_TIME_WAIT: begin
            if (s.seg_fin) reply_ack = 1'b1;
          end
          default: ;
        endcase
        if (reply_ack) begin
          r.action = ACT_ACK;
          r.out_seq = ctx.send_seq;
          r.out_ack_num = ctx.expect_seq;
          r.out_window = window;
          ctx.out_pkts += 32'd1;
          ctx.out_bytes += AckBytes;
        end
        ctx.in_pkts += 32'd1;
        ctx.in_bytes += 32'(s.seg_len);
      end
      r.conn_now   = ctx.conn;
      r.pkts_in    = ctx.in_pkts;
      r.octets_in  = ctx.in_bytes;
      r.pkts_out   = ctx.out_pkts;
      r.octets_out = ctx.out_bytes;
      replies_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(res_t got);
      res_t want;
      if (replies_due.size() == 0) begin
        $error("result beat with no segment outstanding");
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      compare_field("action", 32'(want.action), 32'(got.action));
      compare_field("out_seq", want.out_seq, got.out_seq);
      compare_field("out_ack_num", want.out_ack_num, got.out_ack_num);
      compare_field("out_window", 32'(want.out_window), 32'(got.out_window));
      compare_field("conn_now", 32'(want.conn_now), 32'(got.conn_now));
      compare_field("pkts_in", want.pkts_in, got.pkts_in);
      compare_field("octets_in", want.octets_in, got.octets_in);
      compare_field("pkts_out", want.pkts_out, got.pkts_out);
      compare_field("octets_out", want.octets_out, got.octets_out);
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wen;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;
  int unsigned          send_gap_pct;
  int unsigned          recv_stall_pct;
  conn_tracker          tracker;

  tcsm_seg_if seg_ch ();
  tcsm_res_if res_ch ();

  tcp_connection_state_machine u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .seg       (seg_ch),
    .res       (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    res_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.action      = action_t'(res_ch.action);
      got.out_seq     = res_ch.out_seq;
      got.out_ack_num = res_ch.out_ack_num;
      got.out_window  = res_ch.out_window;
      got.conn_now    = res_ch.conn_now;
      got.pkts_in     = res_ch.pkts_in;
      got.octets_in   = res_ch.octets_in;
      got.pkts_out    = res_ch.pkts_out;
      got.octets_out  = res_ch.octets_out;
      tracker.check_reply(got);
    end
  end

  function automatic seg_t make_seg(logic syn, logic ack, logic fin, logic [31:0] seq,
                                    logic [31:0] ackn, int unsigned len, logic csum);
    seg_t s;
    s.seg_syn = syn;
    s.seg_ack = ack;
    s.seg_fin = fin;
    s.seg_seq = seq;
    s.seg_ack_num = ackn;
    s.seg_len = 11'(len);
    s.checksum_ok = csum;
    return s;
  endfunction

  function automatic logic [31:0] ack_number();
    case ($urandom_range(0, 9))
      0: return tracker.ctx.send_seq;
      1: return tracker.ctx.send_seq - 32'($urandom_range(1, 1000));
      2: return $urandom;
      default: return tracker.ctx.send_seq + 32'($urandom_range(1, 1 << 20));
    endcase
  endfunction

  // Mostly segments that move the current state along; some noise and drops.
  function automatic seg_t next_segment();
    seg_t        s;
    int unsigned roll;
    s = make_seg(1'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom,
                 $urandom_range(40, 1500), 1'b1);
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      if ($urandom_range(0, 1) == 0) begin
        s.seg_len = 11'($urandom_range(0, 39));
        s.checksum_ok = 1'($urandom);
      end else begin
        s.seg_len = 11'($urandom_range(0, 1500));
        s.checksum_ok = 1'b0;
      end
    end else if (roll >= 22) begin
      s.seg_syn = 1'b0;
      s.seg_ack = 1'b0;
      s.seg_fin = 1'b0;
      if (roll < 90) s.seg_len = 11'($urandom_range(40, 120));
      case (tracker.ctx.conn)
        ST_LISTEN: begin
          s.seg_syn = 1'b1;
          s.seg_ack = 1'($urandom);
        end
        ST_SYN_SENT: begin
          s.seg_syn = 1'b1;
          s.seg_ack = ($urandom_range(0, 9) != 0);
          s.seg_ack_num = ack_number();
        end
        ST_SYN_RECV, ST_CLOSING, ST_LAST_ACK: begin
          s.seg_ack = 1'b1;
          s.seg_syn = ($urandom_range(0, 9) == 0);
          s.seg_ack_num = ack_number();
        end
        ST_ESTABLISHED, ST_FIN_WAIT1, ST_FIN_WAIT2: begin
          s.seg_ack = 1'b1;
          s.seg_ack_num = ack_number();
          s.seg_fin = ($urandom_range(0, 99) < 20);
        end
        ST_TIME_WAIT: begin
          s.seg_fin = 1'($urandom);
          s.seg_ack = 1'($urandom);
        end
        default: begin
          s.seg_syn = 1'($urandom);
          s.seg_ack = 1'($urandom);
          s.seg_fin = 1'($urandom);
        end
      endcase
    end
    return s;
  endfunction

  task automatic send_segment(input seg_t s);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      seg_ch.valid <= 1'b0;
      @(negedge clk);
    end
    seg_ch.valid       <= 1'b1;
    seg_ch.seg_syn     <= s.seg_syn;
    seg_ch.seg_ack     <= s.seg_ack;
    seg_ch.seg_fin     <= s.seg_fin;
    seg_ch.seg_seq     <= s.seg_seq;
    seg_ch.seg_ack_num <= s.seg_ack_num;
    seg_ch.seg_len     <= s.seg_len;
    seg_ch.checksum_ok <= s.checksum_ok;
    do @(posedge clk); while (!seg_ch.ready);
    tracker.note_segment(s);
  endtask

  // Hold off until every beat has returned, then let the pipeline settle.
  task automatic drain();
    @(negedge clk);
    seg_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.load_register(idx, data);
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic reconfigure(input logic [3:0] start, input logic [31:0] iseq,
                             input logic [15:0] win);
    drain();
    write_reg(CFG_START_STATE, 32'(start));
    write_reg(CFG_INITIAL_SEQ, iseq);
    write_reg(CFG_ADV_WINDOW, 32'(win));
  endtask

  function automatic void set_idling(int unsigned mode);
    case (mode)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 45; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 45; end
      default: begin send_gap_pct = 9; recv_stall_pct = 9; end
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned burst;
    logic [31:0] iseq;
    logic [15:0] win;
    tracker = new();
    set_idling(0);
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_index = CFG_START_STATE;
    cfg_data = '0;
    seg_ch.valid = 1'b0;
    seg_ch.seg_syn = 1'b0;
    seg_ch.seg_ack = 1'b0;
    seg_ch.seg_fin = 1'b0;
    seg_ch.seg_seq = '0;
    seg_ch.seg_ack_num = '0;
    seg_ch.seg_len = '0;
    seg_ch.checksum_ok = 1'b0;
    res_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Drops at the length edge and on a bad checksum, then a passive open.
    send_segment(make_seg(1, 0, 0, 32'h0, 32'h0, 39, 1));
    send_segment(make_seg(1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1500, 0));
    send_segment(make_seg(1, 0, 0, 32'h1234_5678, 32'h0, 0, 1));
    send_segment(make_seg(0, 1, 0, 32'h0000_0010, 32'h0000_0005, 40, 1));
    send_segment(make_seg(1, 0, 0, 32'hFFFF_FFFF, 32'h0, 40, 1));
    send_segment(make_seg(0, 1, 0, 32'h0, 32'h0, 41, 1));
    send_segment(make_seg(0, 1, 0, 32'h0, 32'hFFFF_FFFF, 60, 1));
    send_segment(make_seg(0, 1, 0, 32'h0, 32'hFFFF_FFFF, 60, 1));
    send_segment(make_seg(0, 1, 1, 32'h8000_0000, 32'h0, 1500, 1));
    send_segment(make_seg(1, 1, 1, 32'h5555_5555, 32'hAAAA_AAAA, 1024, 1));

    // Active open with the send sequence at the wrap point and a zero window.
    reconfigure(ST_SYN_SENT, 32'hFFFF_FFFE, 16'h0000);
    send_segment(make_seg(1, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 40, 1));
    send_segment(make_seg(1, 1, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 40, 1));
    send_segment(make_seg(1, 1, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 40, 1));

    reconfigure(ST_FIN_WAIT1, 32'd100, 16'hFFFF);
    send_segment(make_seg(0, 1, 0, 32'd7, 32'd101, 80, 1));
    send_segment(make_seg(0, 0, 1, 32'd7, 32'd0, 80, 1));
    send_segment(make_seg(0, 0, 1, 32'd8, 32'd0, 80, 1));
    send_segment(make_seg(0, 1, 0, 32'd9, 32'd500, 80, 1));

    reconfigure(ST_CLOSING, 32'h0, 16'h1234);
    send_segment(make_seg(0, 1, 0, 32'h0, 32'd5, 52, 1));

    reconfigure(ST_LAST_ACK, 32'h0, 16'h8000);
    send_segment(make_seg(0, 1, 0, 32'h0, 32'd1, 52, 1));
    send_segment(make_seg(1, 1, 1, 32'h0, 32'd9, 52, 1));

    reconfigure(ST_CLOSED, 32'h0, 16'hFFFF);
    send_segment(make_seg(1, 1, 1, 32'h1, 32'h2, 100, 1));

    reconfigure(ST_CLOSE_WAIT, 32'hFFFF_FFFF, 16'h0001);
    send_segment(make_seg(1, 1, 1, 32'h1, 32'h2, 100, 1));

    sent = 0;
    phase = 0;
    while (sent < 1050) begin
      case ($urandom_range(0, 3))
        0: iseq = 32'h0;
        1: iseq = 32'hFFFF_FFFF;
        2: iseq = 32'hFFFF_FFFF - 32'($urandom_range(0, 50));
        default: iseq = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: win = 16'h0000;
        1: win = 16'hFFFF;
        default: win = 16'($urandom);
      endcase
      reconfigure(4'($urandom_range(ST_CLOSED, ST_LAST_ACK)), iseq, win);
      set_idling(phase % 4);
      burst = $urandom_range(15, 45);
      repeat (burst) begin
        send_segment(next_segment());
        sent++;
      end
      phase++;
    end

    drain();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tcsm_pkg.sv
hw/rtl/tcsm_ifs.sv
hw/rtl/tcsm_step.sv
hw/rtl/tcsm_ctx.sv
hw/rtl/tcp_connection_state_machine.sv
hw/rtl/tcsm_checker.sv
test/tb_top.sv
